// File: src/cfmf_pkg.sv
// shared constants, beat types and state encoding for the ring-buffer queue with mean
`timescale 1ns / 1ps
`default_nettype none
package cfmf_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int NUM_W   = 16;
    localparam int MIN_W   = 10;
    localparam int ENTRY_W = NUM_W + MIN_W;
    localparam int OCC_W   = 5;
    localparam int MEAN_W  = 18;
    localparam int STAT_W  = 2;

    // running sum and mean division
    localparam int SUM_W  = MIN_W + IDX_W;
    localparam int FRAC_W = 8;
    localparam int DIV_W  = SUM_W + FRAC_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic             operation;
        logic [NUM_W-1:0] entry_number;
        logic [MIN_W-1:0] entry_minutes;
    } in_beat_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [NUM_W-1:0]  popped_number;
        logic [MIN_W-1:0]  popped_minutes;
        logic [OCC_W-1:0]  occupancy;
        logic [MEAN_W-1:0] mean_minutes;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DELIVER
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic update;
        logic div_start;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_read;
        logic div_busy;
        logic out_stall;
    } sts_t;

endpackage
`default_nettype wire

// File: src/cfmf_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module cfmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/cfmf_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cfmf_div import cfmf_pkg::*; (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              start,
    input  wire [DIV_W-1:0]  dividend,
    input  wire [CNT_W-1:0]  divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [CNT_W:0]    trial;

    always_comb begin
        trial     = {rem_reg, quot_reg[DIV_W-1]};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = DCNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next  = CNT_W'(trial - {1'b0, divisor});
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next  = CNT_W'(trial);
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

// File: src/cfmf_datapath.sv
// queue pointers, running sum, entry store, mean divider and result register
`timescale 1ns / 1ps
`default_nettype none
module cfmf_datapath import cfmf_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  in_beat_t   s_data,
    output logic       m_valid,
    input  wire        m_ready,
    output out_beat_t  m_data
);

    logic              op_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [MIN_W-1:0]  min_reg;
    logic [IDX_W-1:0]  head_reg, tail_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic [NUM_W-1:0]  res_num_reg;
    logic [MIN_W-1:0]  res_min_reg;
    logic              out_valid_reg;
    out_beat_t         out_data_reg;

    logic               is_full, is_empty, push_ok, pop_ok;
    logic [ENTRY_W-1:0] rd_entry;
    logic [MIN_W-1:0]   rd_minutes;
    logic [NUM_W-1:0]   rd_number;
    logic               div_busy;
    logic [DIV_W-1:0]   quotient;
    logic [MEAN_W-1:0]  mean_val;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);
    assign push_ok  = cmd.update && (op_reg == OP_PUSH) && !is_full;
    assign pop_ok   = cmd.update && (op_reg == OP_POP) && !is_empty;

    assign rd_number  = rd_entry[ENTRY_W-1:MIN_W];
    assign rd_minutes = rd_entry[MIN_W-1:0];

    cfmf_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (push_ok),
        .waddr (tail_reg),
        .wdata ({num_reg, min_reg}),
        .re    (cmd.rd_en),
        .raddr (head_reg),
        .rdata (rd_entry)
    );

    cfmf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({sum_reg, FRAC_W'(0)}),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // mean is zero for an empty queue
    assign mean_val = is_empty ? '0 : MEAN_W'(quotient);

    // captured item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_data.operation;
            num_reg <= s_data.entry_number;
            min_reg <= s_data.entry_minutes;
        end
    end

    // queue state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (push_ok) begin
            tail_reg  <= wrap_inc(tail_reg);
            count_reg <= count_reg + 1'b1;
            sum_reg   <= sum_reg + SUM_W'(min_reg);
        end else if (pop_ok) begin
            head_reg  <= wrap_inc(head_reg);
            count_reg <= count_reg - 1'b1;
            sum_reg   <= sum_reg - SUM_W'(rd_minutes);
        end
    end

    // per-item result fields
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            res_num_reg <= '0;
            res_min_reg <= '0;
            if (op_reg == OP_PUSH) begin
                res_status_reg <= is_full ? STATUS_FULL : STATUS_DONE;
            end else if (is_empty) begin
                res_status_reg <= STATUS_EMPTY;
            end else begin
                res_status_reg <= STATUS_DONE;
                res_num_reg    <= rd_number;
                res_min_reg    <= rd_minutes;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            out_data_reg.status         <= res_status_reg;
            out_data_reg.popped_number  <= res_num_reg;
            out_data_reg.popped_minutes <= res_min_reg;
            out_data_reg.occupancy      <= OCC_W'(count_reg);
            out_data_reg.mean_minutes   <= mean_val;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign sts.pop_read  = (s_data.operation == OP_POP) && !is_empty;
    assign sts.div_busy  = div_busy;
    assign sts.out_stall = out_valid_reg && !m_ready;

endmodule
`default_nettype wire

// File: src/cfmf_ctrl.sv
// sequencing state machine for one queue operation
`timescale 1ns / 1ps
`default_nettype none
module cfmf_ctrl import cfmf_pkg::*; (
    input  wire   aclk,
    input  wire   aresetn,
    input  wire   s_valid,
    output logic  s_ready,
    input  sts_t  sts,
    output cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = sts.pop_read ? ST_READ : ST_UPDATE;
                end
            end
            ST_READ:      state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (!sts.div_busy) begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (!sts.out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_READ:      cmd.rd_en     = 1'b1;
            ST_UPDATE:    cmd.update    = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_WAIT:  cmd           = '0;
            ST_DELIVER:   cmd.load_out  = !sts.out_stall;
            default:      cmd           = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: src/circular_fifo_with_mean_field_core.sv
// top level of the ring-buffer queue that reports occupancy and mean service time
`timescale 1ns / 1ps
`default_nettype none
// Ring-buffer queue of QUEUE_DEPTH entries (16), each a 16-bit number and a
// 10-bit service time. An input beat either pushes an entry at the tail or
// pops the head entry; every input beat yields exactly one result beat with a
// status (done, push refused because full, pop on empty queue), the popped
// entry or zeros, the occupancy after the operation and the mean service time
// of the held entries in unsigned fixed point with 8 fraction bits (zero when
// empty, truncated). One item is worked at a time, and a new input beat is
// taken in the cycle after the result is loaded into the output register,
// even while that result still waits for m_ready. The time per item is set
// mostly by the mean division, a restoring divider that produces one of its
// 22 quotient bits per cycle. The entry store is a ram with registered read;
// it needs no clearing after reset since only written entries are popped.
module circular_fifo_with_mean_field_core import cfmf_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    // input beats
    input  wire        s_valid,
    output logic       s_ready,
    input  in_beat_t   s_data,
    // result beats
    output logic       m_valid,
    input  wire        m_ready,
    output out_beat_t  m_data
);

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: capture, store read, queue update, divide, deliver
    cfmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // pointers, running sum, entry ram, divider and output register
    cfmf_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// File: src/cfmf_checker.sv
// port-level checker for the queue core and its bind
`timescale 1ns / 1ps
`default_nettype none
module cfmf_checker import cfmf_pkg::*; (
    input wire       aclk,
    input wire       aresetn,
    input wire       m_valid,
    input wire       m_ready,
    input out_beat_t m_data
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // occupancy never exceeds the depth
    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.occupancy <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // a refused push means the queue is full
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_FULL |->
            m_data.occupancy == OCC_W'(QUEUE_DEPTH))
        else $error("push refused while not full");

    // a pop on empty gives zeros
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_EMPTY |->
            m_data.occupancy == '0 && m_data.popped_number == '0 &&
            m_data.popped_minutes == '0)
        else $error("pop on empty returned data");

    // an empty queue reports zero mean
    a_mean_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.occupancy == '0 |-> m_data.mean_minutes == '0)
        else $error("nonzero mean for empty queue");

endmodule

bind circular_fifo_with_mean_field_core cfmf_checker u_cfmf_checker (.*);
`default_nettype wire

// File: sim/tb_circular_fifo_with_mean_field_core.sv
// self-checking testbench for the ring-buffer queue with occupancy and mean service time
`timescale 1ns / 1ps
`default_nettype none

import cfmf_pkg::*;

// keeps a private copy of the queue and the expected result beats
class queue_scoreboard;

    // predicted queue contents and bookkeeping
    bit [NUM_W-1:0]  number_store  [QUEUE_DEPTH];
    bit [MIN_W-1:0]  minutes_store [QUEUE_DEPTH];
    bit [IDX_W-1:0]  head_ptr;
    bit [IDX_W-1:0]  tail_ptr;
    bit [CNT_W-1:0]  held_count;
    bit [SUM_W-1:0]  held_minutes;

    out_beat_t       expected_beats [$];
    int              errors;

    function new();
        head_ptr     = '0;
        tail_ptr     = '0;
        held_count   = '0;
        held_minutes = '0;
        errors       = 0;
    endfunction

    // truncated mean of held service times, 8 fraction bits
    function bit [MEAN_W-1:0] held_mean();
        bit [31:0] scaled;
        if (held_count == 0) return '0;
        scaled = {{(32 - SUM_W){1'b0}}, held_minutes} << FRAC_W;
        return MEAN_W'(scaled / held_count);
    endfunction

    // accepted input beat: update the queue copy and queue up its result
    function void note_input(in_beat_t b);
        out_beat_t r;
        r = '0;
        if (b.operation == OP_PUSH) begin
            if (held_count >= QUEUE_DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                r.status                = STATUS_DONE;
                number_store[tail_ptr]  = b.entry_number;
                minutes_store[tail_ptr] = b.entry_minutes;
                tail_ptr                = IDX_W'((int'(tail_ptr) + 1) % QUEUE_DEPTH);
                held_count              = held_count + 1'b1;
                held_minutes            = held_minutes + b.entry_minutes;
            end
        end else begin
            if (held_count == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.status         = STATUS_DONE;
                r.popped_number  = number_store[head_ptr];
                r.popped_minutes = minutes_store[head_ptr];
                head_ptr         = IDX_W'((int'(head_ptr) + 1) % QUEUE_DEPTH);
                held_count       = held_count - 1'b1;
                held_minutes     = held_minutes - r.popped_minutes;
            end
        end
        r.occupancy    = OCC_W'(held_count);
        r.mean_minutes = held_mean();
        expected_beats.push_back(r);
    endfunction

    function void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    // accepted result beat: compare with the oldest expectation
    function void check_result(out_beat_t got);
        out_beat_t want;
        if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none actual %h", $time, got);
            errors++;
            return;
        end
        want = expected_beats.pop_front();
        check_field("status",         32'(want.status),         32'(got.status));
        check_field("popped_number",  32'(want.popped_number),  32'(got.popped_number));
        check_field("popped_minutes", 32'(want.popped_minutes), 32'(got.popped_minutes));
        check_field("occupancy",      32'(want.occupancy),      32'(got.occupancy));
        check_field("mean_minutes",   32'(want.mean_minutes),   32'(got.mean_minutes));
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction
endclass

module tb_circular_fifo_with_mean_field_core;
    import cfmf_pkg::*;

    localparam int RANDOM_BEATS = 500;
    localparam int HOLD_CYCLES  = 300;   // long receiver stall, fills the block up
    localparam int HOLD_AT      = 60;    // result count at which the stall starts
    localparam int DRAIN_CYCLES = 60;    // wait after the last expected beat to catch stray ones

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    queue_scoreboard sb;

    // idle percentages per side, changed by the stimulus between phases
    int src_idle_pct;
    int sink_idle_pct;

    // receiver side bookkeeping
    int results_seen = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    circular_fifo_with_mean_field_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // hard stop, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // build one input beat
    function automatic in_beat_t make_beat(logic op, logic [NUM_W-1:0] num,
                                           logic [MIN_W-1:0] mins);
        in_beat_t b;
        b.operation     = op;
        b.entry_number  = num;
        b.entry_minutes = mins;
        return b;
    endfunction

    // random beat, pushes with the given percentage; fields random on pops too
    function automatic in_beat_t random_beat(int push_pct);
        logic op;
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        return make_beat(op, NUM_W'($urandom_range(65535)), MIN_W'($urandom_range(1023)));
    endfunction

    // offer one beat from a falling edge, return at the falling edge after acceptance
    task automatic send_beat(in_beat_t b);
        // random gap before the beat; valid only drops between beats
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = b;
        // hold the beat until the block takes it
        do @(posedge aclk); while (!s_ready);
        sb.note_input(b);
        @(negedge aclk);
    endtask

    // result sampling at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
            results_seen = results_seen + 1;
        end
    end

    // receiver ready, driven at the falling edge; one long stall counted here
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (hold_left > 0) begin
            m_ready   = 1'b0;
            hold_left = hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready   = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        int push_pct;
        int bias_sel;

        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        src_idle_pct  = 20;
        sink_idle_pct = 46;
        push_pct      = 50;

        // synchronous reset, released at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: pop on empty queue, extreme fields, drain back to empty
        send_beat(make_beat(OP_POP,  16'h0000, 10'd0));
        send_beat(make_beat(OP_PUSH, 16'hFFFF, 10'd1023));
        send_beat(make_beat(OP_PUSH, 16'h0000, 10'd0));
        send_beat(make_beat(OP_POP,  16'hFFFF, 10'd1023));
        send_beat(make_beat(OP_POP,  16'h0000, 10'd0));
        send_beat(make_beat(OP_POP,  16'hA5A5, 10'd512));

        // directed: fill with the largest service time, giving the largest mean
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            send_beat(make_beat(OP_PUSH, NUM_W'(16'h8000 + i), 10'd1023));
        end
        // push refused because full, then pop from a full queue
        send_beat(make_beat(OP_PUSH, 16'h5A5A, 10'd1));
        send_beat(make_beat(OP_POP,  16'h0000, 10'd0));

        // random part in three idling phases; push bias drifts in runs of 32 beats
        // so the queue keeps hitting both full and empty
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 3) begin
                src_idle_pct  = 46;
                sink_idle_pct = 20;
            end else if (n == 2 * RANDOM_BEATS / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (n % 32 == 0) begin
                bias_sel = $urandom_range(2);
                push_pct = (bias_sel == 0) ? 15 : (bias_sel == 1) ? 50 : 85;
            end
            send_beat(random_beat(push_pct));
        end
        s_valid = 1'b0;

        // wait for every expected beat, then watch for stray ones
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
